// ----- rtl/trpc_pkg.sv -----
// Shared types, sizes and helpers for the textured polygon rectangle clipper.
// Used by trpc_ram, trpc_div_unit and the top level; depends on nothing else.
package trpc_pkg;

   localparam int MAX_VERTS = 32;
   localparam int FRAC_BITS = 8;
   localparam int OUT_CAP   = 36;
   localparam int DEPTH     = (MAX_VERTS > OUT_CAP) ? MAX_VERTS : OUT_CAP;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam int COORD_W = 24;
   localparam int WORD_W  = 4 * COORD_W;
   localparam int BND_W   = 13;
   localparam int B_W     = BND_W + FRAC_BITS + 1;
   localparam int AX_W    = ((B_W > COORD_W) ? B_W : COORD_W) + 1;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = AX_W + DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int ITER_W  = $clog2(PROD_W);

   // Field slots of one stored vertex word, lowest first.
   localparam logic [1:0] F_X = 2'd0;
   localparam logic [1:0] F_Y = 2'd1;
   localparam logic [1:0] F_U = 2'd2;
   localparam logic [1:0] F_V = 2'd3;

   localparam logic [1:0] REG_LEFT   = 2'd0;
   localparam logic [1:0] REG_RIGHT  = 2'd1;
   localparam logic [1:0] REG_TOP    = 2'd2;
   localparam logic [1:0] REG_BOTTOM = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic                              start;
      logic signed [COORD_W-1:0]         c_prev;
      logic signed [COORD_W-1:0]         c_cur;
      logic signed [AX_W-1:0]            t_num;
      logic signed [AX_W-1:0]            d_den;
   } div_req_type;

   typedef struct packed {
      logic                              busy;
      logic                              done;
      logic signed [COORD_W-1:0]         value;
   } div_rsp_type;

   function automatic logic signed [COORD_W-1:0] field_of(input word_type w,
                                                          input logic [1:0] sel);
      logic signed [COORD_W-1:0] r;
      unique case (sel)
         F_X: r = w[COORD_W-1:0];
         F_Y: r = w[2*COORD_W-1:COORD_W];
         F_U: r = w[3*COORD_W-1:2*COORD_W];
         F_V: r = w[4*COORD_W-1:3*COORD_W];
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = -hi - SUM_W'(1);
      if (v > hi) return hi[COORD_W-1:0];
      else if (v < lo) return lo[COORD_W-1:0];
      else return v[COORD_W-1:0];
   endfunction

endpackage

// ----- rtl/trpc_ram.sv -----
// Vertex store: one write port and one read port with registered read data.
// Depends on trpc_pkg for depth and word width.
module trpc_ram (
   input  logic                      clock,
   input  logic                      we,
   input  logic [trpc_pkg::IDX_W-1:0] waddr,
   input  trpc_pkg::word_type        wdata,
   input  logic [trpc_pkg::IDX_W-1:0] raddr,
   output trpc_pkg::word_type        rdata
);

   trpc_pkg::word_type mem [trpc_pkg::DEPTH];
   trpc_pkg::word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/trpc_div_unit.sv -----
// Shared interpolation unit: c_prev + (c_cur - c_prev) * t / d, truncated toward zero,
// saturated to 24 bits. One multiply, then a restoring divide at one bit per cycle.
// Depends on trpc_pkg.
module trpc_div_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  trpc_pkg::div_req_type req,
   output trpc_pkg::div_rsp_type rsp
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_MUL  = 3'd1;
   localparam logic [2:0] U_ABS  = 3'd2;
   localparam logic [2:0] U_DIV  = 3'd3;
   localparam logic [2:0] U_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [trpc_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic signed [trpc_pkg::COORD_W-1:0] cp_ff, cp_in;
   logic signed [trpc_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [trpc_pkg::AX_W-1:0]    t_ff, t_in;
   logic signed [trpc_pkg::AX_W-1:0]    d_ff, d_in;
   logic signed [trpc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [trpc_pkg::PROD_W-1:0]         num_ff, num_in;
   logic [trpc_pkg::AX_W-1:0]           den_ff, den_in;
   logic [trpc_pkg::AX_W-1:0]           rem_ff, rem_in;
   logic                                neg_ff, neg_in;
   logic signed [trpc_pkg::COORD_W-1:0] res_ff, res_in;
   logic                                done_ff, done_in;

   logic [trpc_pkg::AX_W:0]             shifted;
   logic [trpc_pkg::AX_W:0]             trial;
   logic signed [trpc_pkg::SUM_W-1:0]   quot;
   logic signed [trpc_pkg::SUM_W-1:0]   total;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cp_in    = cp_ff;
      diff_in  = diff_ff;
      t_in     = t_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, num_ff[trpc_pkg::PROD_W-1]};
      trial    = shifted - {1'b0, den_ff};
      quot     = neg_ff ? -signed'({1'b0, num_ff}) : signed'({1'b0, num_ff});
      total    = quot + trpc_pkg::SUM_W'(cp_ff);
      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               cp_in    = req.c_prev;
               diff_in  = trpc_pkg::DIFF_W'(req.c_cur) - trpc_pkg::DIFF_W'(req.c_prev);
               t_in     = req.t_num;
               d_in     = req.d_den;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            prod_in  = trpc_pkg::PROD_W'(diff_ff) * trpc_pkg::PROD_W'(t_ff);
            state_in = U_ABS;
         end
         U_ABS: begin
            num_in   = prod_ff[trpc_pkg::PROD_W-1] ? trpc_pkg::PROD_W'(-prod_ff)
                                                   : trpc_pkg::PROD_W'(prod_ff);
            den_in   = d_ff[trpc_pkg::AX_W-1] ? trpc_pkg::AX_W'(-d_ff) : trpc_pkg::AX_W'(d_ff);
            neg_in   = prod_ff[trpc_pkg::PROD_W-1] ^ d_ff[trpc_pkg::AX_W-1];
            rem_in   = '0;
            iter_in  = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            if (!trial[trpc_pkg::AX_W]) begin
               rem_in = trial[trpc_pkg::AX_W-1:0];
               num_in = {num_ff[trpc_pkg::PROD_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[trpc_pkg::AX_W-1:0];
               num_in = {num_ff[trpc_pkg::PROD_W-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == trpc_pkg::ITER_W'(trpc_pkg::PROD_W - 1)) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            res_in   = trpc_pkg::sat_coord(total);
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff <= iter_in;
      cp_ff   <= cp_in;
      diff_ff <= diff_in;
      t_ff    <= t_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign rsp.busy  = (state_ff != U_IDLE);
   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

   // A result is only flagged in the cycle after the final step.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff) == U_FIN)
      else $error("divider done without final step");

   // The divisor is never zero once the divide runs.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == U_DIV |-> den_ff != '0)
      else $error("zero divisor in interpolation");

   // A new request never arrives while the unit is busy.
   assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == U_IDLE)
      else $error("divider started while busy");

endmodule

// ----- rtl/textured_polygon_rect_clipper_core.sv -----
// Top level of the textured polygon rectangle clipper: loader, pass sequencer and
// output stage around two vertex stores and one shared interpolation unit.
// Depends on trpc_pkg, trpc_ram and trpc_div_unit.
//
// Usage: vertices arrive on the req_ channel, one per beat; req_tlast marks the
// last vertex of a polygon. Bounds are written on the csr_ port while idle.
// Each vertex beat is taken as soon as it is valid while loading. After the last beat
// the polygon is clipped in four passes (left, right, top, bottom); for every crossing
// edge the one shared multiply/divide unit computes the other coordinate, u and v one
// after another. Then the clipped vertices leave on rsp_, the next one read from the
// store only after the previous beat is taken, the last with rsp_tlast; an empty or
// oversized polygon gives one flagged beat.
// req_tready stays low from the last vertex until the last result beat is taken.
// When the receiver stalls, the result beat holds in its register.
// Reset restores the default bounds and empties the loader; no store clearing
// is needed, since only entries written for the current polygon are read.
module textured_polygon_rect_clipper_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [trpc_pkg::WORD_W-1:0]     req_tdata,  // pos_x, pos_y, tex_u, tex_v
   input  logic                            req_tlast,  // final_vertex
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [trpc_pkg::WORD_W-1:0]     rsp_tdata,  // out_x, out_y, out_u, out_v
   output logic                            rsp_tlast,  // end_of_polygon
   output logic [1:0]                      rsp_tuser,  // fully_clipped, too_many
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [trpc_pkg::BND_W-1:0]      csr_wdata
);

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_INIT   = 4'd1;
   localparam logic [3:0] S_PRV    = 4'd2;
   localparam logic [3:0] S_RDC    = 4'd3;
   localparam logic [3:0] S_CUR    = 4'd4;
   localparam logic [3:0] S_EMIT   = 4'd5;
   localparam logic [3:0] S_XSTART = 4'd6;
   localparam logic [3:0] S_XWAIT  = 4'd7;
   localparam logic [3:0] S_XPUT   = 4'd8;
   localparam logic [3:0] S_NEXT   = 4'd9;
   localparam logic [3:0] S_ORD    = 4'd10;
   localparam logic [3:0] S_OCAP   = 4'd11;
   localparam logic [3:0] S_OWAIT  = 4'd12;

   localparam int CW = trpc_pkg::COORD_W;

   logic [3:0] state_ff, state_in;
   logic [trpc_pkg::BND_W-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic [trpc_pkg::CNT_W-1:0] load_ff, load_in;
   logic                       ovf_ff, ovf_in;
   logic [trpc_pkg::CNT_W-1:0] n_ff, n_in;
   logic [trpc_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [trpc_pkg::CNT_W-1:0] ocnt_ff, ocnt_in;
   logic [1:0]                 pass_ff, pass_in;
   logic [1:0]                 comp_ff, comp_in;
   trpc_pkg::word_type         prev_ff, prev_in;
   trpc_pkg::word_type         cur_ff, cur_in;
   trpc_pkg::word_type         cross_ff, cross_in;
   logic                       rv_ff, rv_in;
   trpc_pkg::word_type         rd_ff, rd_in;
   logic                       rl_ff, rl_in;
   logic [1:0]                 ru_ff, ru_in;

   logic                        ping_we, pong_we;
   logic [trpc_pkg::IDX_W-1:0]  waddr, raddr;
   trpc_pkg::word_type          wdata, ping_rd, pong_rd, src_rd;
   trpc_pkg::div_req_type       dreq;
   trpc_pkg::div_rsp_type       drsp;

   logic                        axis_y, keep_ge, pin, cin;
   logic [trpc_pkg::BND_W-1:0]  bound_sel;
   logic signed [trpc_pkg::AX_W-1:0] b_ext, ap_ext, ac_ext;
   logic signed [CW-1:0]        b_sat;
   logic [1:0]                  axis_f, other_f, comp_f;
   logic                        accept;

   trpc_ram u_ping (.clock(clock), .we(ping_we), .waddr(waddr), .wdata(wdata),
                    .raddr(raddr), .rdata(ping_rd));
   trpc_ram u_pong (.clock(clock), .we(pong_we), .waddr(waddr), .wdata(wdata),
                    .raddr(raddr), .rdata(pong_rd));
   trpc_div_unit u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= trpc_pkg::BND_W'(4096);
         top_ff    <= '0;
         bottom_ff <= trpc_pkg::BND_W'(4096);
      end else if (csr_we) begin
         unique case (csr_addr)
            trpc_pkg::REG_LEFT:   left_ff   <= csr_wdata;
            trpc_pkg::REG_RIGHT:  right_ff  <= csr_wdata;
            trpc_pkg::REG_TOP:    top_ff    <= csr_wdata;
            trpc_pkg::REG_BOTTOM: bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pass order is left, right, top, bottom; odd passes write back into ping.
   always_comb begin
      axis_y  = pass_ff[1];
      keep_ge = !pass_ff[0];
      unique case (pass_ff)
         2'd0: bound_sel = left_ff;
         2'd1: bound_sel = right_ff;
         2'd2: bound_sel = top_ff;
         2'd3: bound_sel = bottom_ff;
         default: bound_sel = '0;
      endcase
      b_ext   = trpc_pkg::AX_W'({bound_sel, {trpc_pkg::FRAC_BITS{1'b0}}});
      b_sat   = trpc_pkg::sat_coord(trpc_pkg::SUM_W'(b_ext));
      axis_f  = axis_y ? trpc_pkg::F_Y : trpc_pkg::F_X;
      other_f = axis_y ? trpc_pkg::F_X : trpc_pkg::F_Y;
      ap_ext  = trpc_pkg::AX_W'(trpc_pkg::field_of(prev_ff, axis_f));
      ac_ext  = trpc_pkg::AX_W'(trpc_pkg::field_of(cur_ff, axis_f));
      pin     = keep_ge ? (ap_ext >= b_ext) : (ap_ext < b_ext);
      cin     = keep_ge ? (ac_ext >= b_ext) : (ac_ext < b_ext);
      unique case (comp_ff)
         2'd0:    comp_f = other_f;
         2'd1:    comp_f = trpc_pkg::F_U;
         default: comp_f = trpc_pkg::F_V;
      endcase
      src_rd = (pass_ff[0] || state_ff == S_OCAP) ? pong_rd : ping_rd;
      if (state_ff == S_OCAP) src_rd = ping_rd;
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      load_in  = load_ff;
      ovf_in   = ovf_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      ocnt_in  = ocnt_ff;
      pass_in  = pass_ff;
      comp_in  = comp_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      cross_in = cross_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;
      rl_in    = rl_ff;
      ru_in    = ru_ff;
      ping_we  = 1'b0;
      pong_we  = 1'b0;
      waddr    = ocnt_ff[trpc_pkg::IDX_W-1:0];
      wdata    = prev_ff;
      raddr    = idx_ff[trpc_pkg::IDX_W-1:0];
      dreq.start  = 1'b0;
      dreq.c_prev = trpc_pkg::field_of(prev_ff, comp_f);
      dreq.c_cur  = trpc_pkg::field_of(cur_ff, comp_f);
      dreq.t_num  = b_ext - ap_ext;
      dreq.d_den  = ac_ext - ap_ext;
      unique case (state_ff)
         S_LOAD: begin
            waddr = load_ff[trpc_pkg::IDX_W-1:0];
            wdata = req_tdata;
            if (accept) begin
               if (!ovf_ff && load_ff < trpc_pkg::CNT_W'(trpc_pkg::MAX_VERTS)) begin
                  ping_we = 1'b1;
                  load_in = load_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  load_in = '0;
                  ovf_in  = 1'b0;
                  if (ovf_ff || load_ff == trpc_pkg::CNT_W'(trpc_pkg::MAX_VERTS)) begin
                     rv_in = 1'b1; rd_in = '0; rl_in = 1'b1; ru_in = 2'b10;
                     state_in = S_OWAIT;
                  end else begin
                     n_in     = load_ff + 1'b1;
                     pass_in  = 2'd0;
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_INIT: begin
            raddr    = trpc_pkg::IDX_W'(n_ff - 1'b1);
            state_in = S_PRV;
         end
         S_PRV: begin
            prev_in  = src_rd;
            idx_in   = '0;
            ocnt_in  = '0;
            state_in = S_RDC;
         end
         S_RDC: state_in = S_CUR;
         S_CUR: begin
            cur_in   = src_rd;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            state_in = (pin != cin) ? S_XSTART : S_NEXT;
            comp_in  = 2'd0;
            if (pin) begin
               if (ocnt_ff == trpc_pkg::CNT_W'(trpc_pkg::OUT_CAP)) begin
                  rv_in = 1'b1; rd_in = '0; rl_in = 1'b1; ru_in = 2'b10;
                  state_in = S_OWAIT;
               end else begin
                  ping_we = pass_ff[0];
                  pong_we = !pass_ff[0];
                  ocnt_in = ocnt_ff + 1'b1;
               end
            end
         end
         S_XSTART: begin
            if (ocnt_ff == trpc_pkg::CNT_W'(trpc_pkg::OUT_CAP)) begin
               rv_in = 1'b1; rd_in = '0; rl_in = 1'b1; ru_in = 2'b10;
               state_in = S_OWAIT;
            end else begin
               dreq.start = 1'b1;
               if (comp_ff == 2'd0) begin
                  if (axis_y) cross_in[2*CW-1:CW] = b_sat;
                  else        cross_in[CW-1:0]    = b_sat;
               end
               state_in = S_XWAIT;
            end
         end
         S_XWAIT: begin
            if (drsp.done) begin
               unique case (comp_f)
                  trpc_pkg::F_X: cross_in[CW-1:0]      = drsp.value;
                  trpc_pkg::F_Y: cross_in[2*CW-1:CW]   = drsp.value;
                  trpc_pkg::F_U: cross_in[3*CW-1:2*CW] = drsp.value;
                  trpc_pkg::F_V: cross_in[4*CW-1:3*CW] = drsp.value;
                  default: ;
               endcase
               comp_in  = comp_ff + 1'b1;
               state_in = (comp_ff == 2'd2) ? S_XPUT : S_XSTART;
            end
         end
         S_XPUT: begin
            wdata    = cross_ff;
            ping_we  = pass_ff[0];
            pong_we  = !pass_ff[0];
            ocnt_in  = ocnt_ff + 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            prev_in = cur_ff;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_ff) begin
               n_in = ocnt_ff;
               if (ocnt_ff == '0) begin
                  rv_in = 1'b1; rd_in = '0; rl_in = 1'b1; ru_in = 2'b01;
                  state_in = S_OWAIT;
               end else if (pass_ff == 2'd3) begin
                  idx_in   = '0;
                  state_in = S_ORD;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  state_in = S_INIT;
               end
            end else begin
               state_in = S_RDC;
            end
         end
         S_ORD: state_in = S_OCAP;
         S_OCAP: begin
            rv_in    = 1'b1;
            rd_in    = src_rd;
            rl_in    = (idx_ff + 1'b1 == n_ff);
            ru_in    = 2'b00;
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            if (rsp_tready) begin
               rv_in = 1'b0;
               if (rl_ff) begin
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         load_ff  <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         ocnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         load_ff  <= load_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
         ocnt_ff  <= ocnt_in;
      end
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      pass_ff  <= pass_in;
      comp_ff  <= comp_in;
      prev_ff  <= prev_in;
      cur_ff   <= cur_in;
      cross_ff <= cross_in;
      rd_ff    <= rd_in;
      rl_ff    <= rl_in;
      ru_ff    <= ru_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;
   assign rsp_tuser  = ru_ff;

   // Loader and output never overlap.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result beat is pending");

   // The loaded vertex count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      load_ff <= trpc_pkg::CNT_W'(trpc_pkg::MAX_VERTS))
      else $error("loaded vertex count past capacity");

   // The pass output count never passes the pass capacity.
   assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= trpc_pkg::CNT_W'(trpc_pkg::OUT_CAP))
      else $error("pass output count past capacity");

   // The interpolation unit only runs during a crossing.
   assert property (@(posedge clock) disable iff (reset)
      drsp.busy |-> state_ff == S_XWAIT)
      else $error("interpolation unit busy outside a crossing");

endmodule

// ----- verif/tb_textured_polygon_rect_clipper_core.sv -----
// Self-checking testbench for the textured polygon rectangle clipper core.
// Drives polygons on req_, checks clipped vertices on rsp_ against a local model.
// Depends on trpc_pkg and the RTL of textured_polygon_rect_clipper_core.
module tb_textured_polygon_rect_clipper_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        last;
      logic [23:0] v;
      logic [23:0] u;
      logic [23:0] y;
      logic [23:0] x;
   } vertex_beat_type;

   typedef struct {
      logic [23:0] x, y, u, v;
      logic        eop, empty, many;
   } clip_vertex_type;

   typedef struct {
      longint x, y, u, v;
   } fix_vertex_type;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_tvalid = 0;
   logic                           req_tready;
   logic [trpc_pkg::WORD_W-1:0]    req_tdata = '0;
   logic                           req_tlast = 0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 0;
   logic [trpc_pkg::WORD_W-1:0]    rsp_tdata;
   logic                           rsp_tlast;
   logic [1:0]                     rsp_tuser;
   logic                           csr_we = 0;
   logic [1:0]                     csr_addr = trpc_pkg::REG_LEFT;
   logic [trpc_pkg::BND_W-1:0]     csr_wdata = '0;

   textured_polygon_rect_clipper_core DUT (.*);

   vertex_beat_type  pending_beats[$];
   clip_vertex_type  expected_vertices[$];
   fix_vertex_type   poly_verts[$];
   logic [12:0]      bounds[4];
   bit               overflow_seen;
   int               error_count = 0;
   int               hold_off = 0;
   int               stall_count = 0;
   logic             req_fire = 0;
   logic             rsp_fire = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic longint sat24(input longint val);
      if (val > 8388607) return 8388607;
      if (val < -8388608) return -8388608;
      return val;
   endfunction

   function automatic longint coord_of(input fix_vertex_type p, input int axis);
      return axis == 0 ? p.x : p.y;
   endfunction

   // One Sutherland-Hodgman pass; returns 0 if the pass grew past capacity.
   function automatic bit clip_edge(ref fix_vertex_type poly[$], input int axis,
                                    input logic [12:0] bnd, input bit keep_ge);
      fix_vertex_type res[$];
      fix_vertex_type pv, cv, nv;
      longint b, t, d;
      bit pin, cin;
      int n;
      n = poly.size();
      b = longint'(bnd) <<< trpc_pkg::FRAC_BITS;
      for (int i = 0; i < n; i++) begin
         pv = poly[(i == 0) ? n - 1 : i - 1];
         cv = poly[i];
         pin = keep_ge ? coord_of(pv, axis) >= b : coord_of(pv, axis) < b;
         cin = keep_ge ? coord_of(cv, axis) >= b : coord_of(cv, axis) < b;
         if (pin) begin
            if (res.size() >= trpc_pkg::OUT_CAP) return 0;
            res.push_back(pv);
         end
         if (pin != cin) begin
            if (res.size() >= trpc_pkg::OUT_CAP) return 0;
            t = b - coord_of(pv, axis);
            d = coord_of(cv, axis) - coord_of(pv, axis);
            if (axis == 0) begin
               nv.x = sat24(b);
               nv.y = sat24(pv.y + (cv.y - pv.y) * t / d);
            end else begin
               nv.y = sat24(b);
               nv.x = sat24(pv.x + (cv.x - pv.x) * t / d);
            end
            nv.u = sat24(pv.u + (cv.u - pv.u) * t / d);
            nv.v = sat24(pv.v + (cv.v - pv.v) * t / d);
            res.push_back(nv);
         end
      end
      poly = res;
      return 1;
   endfunction

   task automatic push_flag(input bit empty, input bit many);
      clip_vertex_type e;
      e = '{24'd0, 24'd0, 24'd0, 24'd0, 1'b1, empty, many};
      expected_vertices.push_back(e);
   endtask

   task automatic predict_clip(input vertex_beat_type b);
      fix_vertex_type p;
      clip_vertex_type e;
      bit ok;
      if (!overflow_seen) begin
         if (poly_verts.size() < trpc_pkg::MAX_VERTS) begin
            p.x = longint'($signed(b.x)); p.y = longint'($signed(b.y));
            p.u = longint'($signed(b.u)); p.v = longint'($signed(b.v));
            poly_verts.push_back(p);
         end else overflow_seen = 1;
      end
      if (!b.last) return;
      if (overflow_seen) begin
         push_flag(0, 1);
      end else begin
         ok = 1;
         if (poly_verts.size() > 0)
            ok = clip_edge(poly_verts, 0, bounds[trpc_pkg::REG_LEFT], 1);
         if (ok && poly_verts.size() > 0)
            ok = clip_edge(poly_verts, 0, bounds[trpc_pkg::REG_RIGHT], 0);
         if (ok && poly_verts.size() > 0)
            ok = clip_edge(poly_verts, 1, bounds[trpc_pkg::REG_TOP], 1);
         if (ok && poly_verts.size() > 0)
            ok = clip_edge(poly_verts, 1, bounds[trpc_pkg::REG_BOTTOM], 0);
         if (!ok) push_flag(0, 1);
         else if (poly_verts.size() == 0) push_flag(1, 0);
         else foreach (poly_verts[k]) begin
            e.x = poly_verts[k].x[23:0]; e.y = poly_verts[k].y[23:0];
            e.u = poly_verts[k].u[23:0]; e.v = poly_verts[k].v[23:0];
            e.eop = (k == poly_verts.size() - 1); e.empty = 0; e.many = 0;
            expected_vertices.push_back(e);
         end
      end
      poly_verts.delete();
      overflow_seen = 0;
   endtask

   // Handshakes are recorded at the rising edge where they happen.
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
   end

   // Driver: one beat per pending item, with a random gap before each, and random rsp_tready stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            predict_clip(pending_beats.pop_front());
            hold_off = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
         end
         if (hold_off > 0) begin
            hold_off--;
            req_tvalid <= 0;
         end else if (pending_beats.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= {pending_beats[0].v, pending_beats[0].u,
                          pending_beats[0].y, pending_beats[0].x};
            req_tlast <= pending_beats[0].last;
         end else req_tvalid <= 0;
         if (rsp_fire)
            stall_count = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
         if (stall_count > 0) begin
            stall_count--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Monitor: compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      clip_vertex_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0)
            report_mismatch("unexpected beat", rsp_tdata[23:0], 0);
         else begin
            e = expected_vertices.pop_front();
            if (rsp_tdata[23:0] !== e.x) report_mismatch("out_x", rsp_tdata[23:0], e.x);
            if (rsp_tdata[47:24] !== e.y) report_mismatch("out_y", rsp_tdata[47:24], e.y);
            if (rsp_tdata[71:48] !== e.u) report_mismatch("out_u", rsp_tdata[71:48], e.u);
            if (rsp_tdata[95:72] !== e.v) report_mismatch("out_v", rsp_tdata[95:72], e.v);
            if (rsp_tlast !== e.eop) report_mismatch("end_of_polygon", rsp_tlast, e.eop);
            if (rsp_tuser[0] !== e.empty)
               report_mismatch("fully_clipped", rsp_tuser[0], e.empty);
            if (rsp_tuser[1] !== e.many) report_mismatch("too_many", rsp_tuser[1], e.many);
         end
      end
   end

   task automatic add_vertex(input int x, input int y, input int u, input int v,
                             input bit last);
      vertex_beat_type b;
      b.x = x[23:0]; b.y = y[23:0]; b.u = u[23:0]; b.v = v[23:0]; b.last = last;
      pending_beats.push_back(b);
   endtask

   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_tvalid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_bound(input logic [1:0] idx, input logic [12:0] val);
      @(negedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= val;
      bounds[idx] = val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Coordinates mostly near the window so that many edges cross a bound.
   function automatic int rand_coord(input int lo, input int hi);
      if ($urandom_range(0, 15) == 0) return $urandom();
      return $urandom_range(lo << 8, hi << 8) - 256;
   endfunction

   task automatic random_polygon(input int nverts, input int lo, input int hi);
      for (int i = 0; i < nverts; i++)
         add_vertex(rand_coord(lo, hi), rand_coord(lo, hi), $urandom(), $urandom(),
                    i == nverts - 1);
   endtask

   initial begin
      int n;
      bounds[trpc_pkg::REG_LEFT] = 0; bounds[trpc_pkg::REG_RIGHT] = 4096;
      bounds[trpc_pkg::REG_TOP] = 0; bounds[trpc_pkg::REG_BOTTOM] = 4096;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 0;

      // Directed: fully inside, straddling every bound, empty, extremes, single vertex.
      add_vertex(256, 256, 0, 0, 0); add_vertex(2560, 256, 8388607, 0, 0);
      add_vertex(2560, 2560, -8388608, 8388607, 1);
      add_vertex(-8388608, -8388608, -8388608, -8388608, 0);
      add_vertex(8388607, -8388608, 8388607, -8388608, 0);
      add_vertex(8388607, 8388607, 8388607, 8388607, 0);
      add_vertex(-8388608, 8388607, -8388608, 8388607, 1);
      add_vertex(-1000, -1000, 5, 5, 0); add_vertex(-500, -900, 7, 7, 1);
      add_vertex(1048576, 1048576, 1, 2, 1);
      wait_drained();
      write_bound(trpc_pkg::REG_LEFT, 100); write_bound(trpc_pkg::REG_RIGHT, 200);
      write_bound(trpc_pkg::REG_TOP, 50); write_bound(trpc_pkg::REG_BOTTOM, 150);
      add_vertex(0, 0, 0, 0, 0); add_vertex(300 << 8, 0, 1 << 16, 0, 0);
      add_vertex(300 << 8, 300 << 8, 1 << 16, 1 << 16, 0);
      add_vertex(0, 300 << 8, 0, 1 << 16, 1);
      // More than the store holds: overflow result.
      for (int i = 0; i <= trpc_pkg::MAX_VERTS; i++)
         add_vertex(i * 300, i * 77, i, -i, i == trpc_pkg::MAX_VERTS);
      wait_drained();

      // Random phases over several windows, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_bound(trpc_pkg::REG_LEFT, 0); write_bound(trpc_pkg::REG_RIGHT, 8191);
               write_bound(trpc_pkg::REG_TOP, 0); write_bound(trpc_pkg::REG_BOTTOM, 8191); end
            1: begin write_bound(trpc_pkg::REG_LEFT, 8191); write_bound(trpc_pkg::REG_RIGHT, 0); end
            default: for (int r = 0; r < 4; r++) begin
               n = $urandom_range(0, 64);
               write_bound(r[1:0], r[0] ? 13'(64 + n) : 13'(n));
            end
         endcase
         for (int p = 0; p < 4; p++)
            random_polygon(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                       : $urandom_range(3, 6), 0, 140);
         if (ph == 3) random_polygon(trpc_pkg::MAX_VERTS, 0, 140);
         wait_drained();
      end

      wait_drained();
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
